// ===== rtl/sem_pkg.sv =====
package sem_pkg;

	localparam int MAX_WIDTH   = 2048;
	localparam int CHANNELS    = 4;
	localparam int MAX_HEIGHT  = 4096;
	localparam int WIDTH_BITS  = 12;
	localparam int HEIGHT_BITS = 13;
	localparam int CFG_BITS    = 13;
	localparam int PIX_BITS    = 8 * CHANNELS;
	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;
	localparam int FULL_SCALE  = 255;
	// Gain of 64 on the magnitude becomes a factor 4096 on the squared sum.
	localparam int GAIN_SHIFT  = 12;
	localparam int TAPS        = 9;

	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_GRAD,
		ST_SQUARE,
		ST_ROOT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic take;
		logic read;
		logic grad;
		logic square;
		logic root;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic emit;
		logic read_done;
		logic root_done;
		logic out_free;
	} status_t;

endpackage

// ===== rtl/sem_if.sv =====
interface sem_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_in;
	logic [7:0] green_in;
	logic [7:0] blue_in;
	logic [7:0] alpha_in;
	logic       drain;

	modport source(output valid, red_in, green_in, blue_in, alpha_in, drain, input ready);
	modport sink(input valid, red_in, green_in, blue_in, alpha_in, drain, output ready);
endinterface

interface sem_edge_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_edge;
	logic [7:0] green_edge;
	logic [7:0] blue_edge;
	logic [7:0] alpha_out;
	logic       frame_end;

	modport source(output valid, red_edge, green_edge, blue_edge, alpha_out, frame_end,
		input ready);
	modport sink(input valid, red_edge, green_edge, blue_edge, alpha_out, frame_end,
		output ready);
endinterface

// ===== rtl/sobel_edge_magnitude_rgb.sv =====
// Sobel 3x3 edge magnitude on R, G and B of an RGBA raster stream, with the
// centre alpha passed through and pixels outside the frame taken as zero.
// Each result follows its input by one row plus one pixel; once the frame is
// in, each drain transfer flushes one pending result. An input transfer that
// yields no result leaves the input ready; one that yields a result holds it
// off through the transfer itself, nine single-port reads of the line buffer
// ring plus the registered read data, gradient and square steps, eight steps of
// the bitwise square root, and the load of the output register, which waits
// while the previous result is still held there. A finished result waits in the
// output register while the next pixel transfer is taken.
module sobel_edge_magnitude_rgb #(
	parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [sem_pkg::CFG_BITS-1:0]  cfg_data,
	sem_pixel_if.sink                     pixels,
	sem_edge_if.source                    edges
);

	sem_pkg::cmd_t    cmd;
	sem_pkg::status_t status;

	sem_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pixels.valid),
		.in_ready (pixels.ready),
		.status   (status),
		.cmd      (cmd)
	);

	sem_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixels    (pixels),
		.edges     (edges),
		.cmd       (cmd),
		.status    (status)
	);

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> status.out_free)
		else $error("result loaded while output register still held");

	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(edges.valid) |-> $past(cmd.load))
		else $error("output valid rose without a load");

	a_busy_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && status.emit) |=> !pixels.ready)
		else $error("input taken while a result was being computed");

endmodule

// ===== rtl/sem_ctrl.sv =====
module sem_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sem_pkg::status_t  status,
	output sem_pkg::cmd_t     cmd
);

	sem_pkg::state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sem_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		unique case (state_q)
			sem_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
				if (in_valid && status.emit) begin
					state_next = sem_pkg::ST_READ;
				end
			end
			sem_pkg::ST_READ: begin
				cmd.read = 1'b1;
				if (status.read_done) begin
					state_next = sem_pkg::ST_GRAD;
				end
			end
			sem_pkg::ST_GRAD: begin
				cmd.grad   = 1'b1;
				state_next = sem_pkg::ST_SQUARE;
			end
			sem_pkg::ST_SQUARE: begin
				cmd.square = 1'b1;
				state_next = sem_pkg::ST_ROOT;
			end
			sem_pkg::ST_ROOT: begin
				cmd.root = 1'b1;
				if (status.root_done) begin
					state_next = sem_pkg::ST_OUT;
				end
			end
			sem_pkg::ST_OUT: begin
				if (status.out_free) begin
					cmd.load   = 1'b1;
					state_next = sem_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = sem_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/sem_dp.sv =====
module sem_dp #(
	parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [sem_pkg::CFG_BITS-1:0]  cfg_data,
	sem_pixel_if.sink                     pixels,
	sem_edge_if.source                    edges,
	input  sem_pkg::cmd_t                 cmd,
	output sem_pkg::status_t              status
);

	localparam int RING = 2 * MAX_WIDTH + 4;
	localparam int AW   = $clog2(RING);
	localparam int CW   = $clog2(MAX_WIDTH + 1);
	localparam int RW   = $clog2(sem_pkg::MAX_HEIGHT + 1);
	localparam int PW   = CW + RW;
	localparam logic signed [AW+1:0] RING_S = (AW+2)'(RING);

	logic [sem_pkg::WIDTH_BITS-1:0]  width_q;
	logic [sem_pkg::HEIGHT_BITS-1:0] height_q;
	logic [CW-1:0] eff_w;
	logic [RW-1:0] eff_h;
	logic [PW-1:0] total;

	logic [PW-1:0] in_pos_q, out_pos_q;
	logic [AW-1:0] wp_q, rp_q;
	logic [CW-1:0] out_col_q;
	logic [RW-1:0] out_row_q;
	logic          complete_q;

	logic [sem_pkg::PIX_BITS-1:0] mem [RING];
	logic [sem_pkg::PIX_BITS-1:0] rdata_s1;
	logic [AW-1:0]                raddr;

	logic [3:0] rd_cnt_q;
	logic       ok_s1;
	logic [sem_pkg::PIX_BITS-1:0] window_q [sem_pkg::TAPS];

	logic signed [11:0] gx_s1 [3];
	logic signed [11:0] gy_s1 [3];
	logic [7:0]         alpha_q;
	logic [21:0]        sq_q [3];
	logic [7:0]         res_q [3];
	logic [2:0]         bit_q;

	logic pixel_in, last_out, restart;
	logic [PW:0] q_next;

	always_comb begin
		if (width_q == '0) begin
			eff_w = CW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			eff_w = CW'(MAX_WIDTH);
		end else begin
			eff_w = CW'(width_q);
		end
		if (height_q == '0) begin
			eff_h = RW'(1);
		end else if (32'(height_q) > sem_pkg::MAX_HEIGHT) begin
			eff_h = RW'(sem_pkg::MAX_HEIGHT);
		end else begin
			eff_h = RW'(height_q);
		end
	end

	assign total    = PW'({{RW{1'b0}}, eff_w} * {{CW{1'b0}}, eff_h});
	assign pixel_in = !pixels.drain && !complete_q;
	assign q_next   = {1'b0, in_pos_q} + (PW+1)'(1);
	assign last_out = ({1'b0, out_pos_q} + (PW+1)'(1)) == {1'b0, total};
	assign restart  = cfg_we || (cmd.load && last_out);

	always_comb begin
		logic emit_raw;
		if (pixel_in) begin
			emit_raw = q_next >= ({1'b0, out_pos_q} + (PW+1)'(eff_w) + (PW+1)'(2));
		end else begin
			emit_raw = complete_q;
		end
		status.emit      = emit_raw && (out_pos_q < total);
		status.read_done = cmd.read && (rd_cnt_q == 4'(sem_pkg::TAPS));
		status.root_done = cmd.root && (bit_q == '0);
		status.out_free  = !edges.valid || edges.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= sem_pkg::WIDTH_BITS'(sem_pkg::RESET_WIDTH);
			height_q <= sem_pkg::HEIGHT_BITS'(sem_pkg::RESET_HEIGHT);
		end else if (cfg_we) begin
			if (cfg_index == sem_pkg::REG_IMAGE_WIDTH) begin
				width_q <= cfg_data[sem_pkg::WIDTH_BITS-1:0];
			end else begin
				height_q <= cfg_data;
			end
		end
	end

	// Frame position counters; any register write or the last output restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_pos_q   <= '0;
			wp_q       <= '0;
			complete_q <= 1'b0;
			out_pos_q  <= '0;
			rp_q       <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
		end else if (restart) begin
			in_pos_q   <= '0;
			wp_q       <= '0;
			complete_q <= 1'b0;
			out_pos_q  <= '0;
			rp_q       <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
		end else begin
			if (cmd.take && pixel_in) begin
				in_pos_q <= q_next[PW-1:0];
				wp_q     <= (wp_q == AW'(RING - 1)) ? '0 : wp_q + AW'(1);
				if (q_next >= {1'b0, total}) begin
					complete_q <= 1'b1;
				end
			end
			if (cmd.load) begin
				out_pos_q <= out_pos_q + PW'(1);
				rp_q      <= (rp_q == AW'(RING - 1)) ? '0 : rp_q + AW'(1);
				if ({1'b0, out_col_q} + (CW+1)'(1) >= {1'b0, eff_w}) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + RW'(1);
				end else begin
					out_col_q <= out_col_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && pixel_in) begin
			mem[wp_q] <= {pixels.alpha_in, pixels.blue_in, pixels.green_in, pixels.red_in};
		end
		rdata_s1 <= mem[raddr];
	end

	// Neighbor address and in-frame test for the tap being fetched.
	logic ok_now;
	always_comb begin
		logic [1:0] rsel, csel;
		logic signed [AW+1:0] s;
		logic up_ok, dn_ok, lf_ok, rt_ok;
		rsel = 2'd1;
		csel = 2'd1;
		unique case (rd_cnt_q)
			4'd0: begin rsel = 2'd0; csel = 2'd0; end
			4'd1: begin rsel = 2'd0; csel = 2'd1; end
			4'd2: begin rsel = 2'd0; csel = 2'd2; end
			4'd3: begin rsel = 2'd1; csel = 2'd0; end
			4'd4: begin rsel = 2'd1; csel = 2'd1; end
			4'd5: begin rsel = 2'd1; csel = 2'd2; end
			4'd6: begin rsel = 2'd2; csel = 2'd0; end
			4'd7: begin rsel = 2'd2; csel = 2'd1; end
			4'd8: begin rsel = 2'd2; csel = 2'd2; end
			default: begin rsel = 2'd1; csel = 2'd1; end
		endcase
		up_ok = out_row_q != '0;
		dn_ok = ({1'b0, out_row_q} + (RW+1)'(1)) < {1'b0, eff_h};
		lf_ok = out_col_q != '0;
		rt_ok = ({1'b0, out_col_q} + (CW+1)'(1)) < {1'b0, eff_w};
		ok_now = !((rsel == 2'd0) && !up_ok) && !((rsel == 2'd2) && !dn_ok)
			&& !((csel == 2'd0) && !lf_ok) && !((csel == 2'd2) && !rt_ok);
		s = signed'({2'b00, rp_q});
		if (rsel == 2'd0) begin
			s = s - signed'((AW+2)'(eff_w));
		end else if (rsel == 2'd2) begin
			s = s + signed'((AW+2)'(eff_w));
		end
		if (csel == 2'd0) begin
			s = s - (AW+2)'(1);
		end else if (csel == 2'd2) begin
			s = s + (AW+2)'(1);
		end
		if (s < 0) begin
			s = s + RING_S;
		end else if (s >= RING_S) begin
			s = s - RING_S;
		end
		raddr = s[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q <= '0;
		end else if (cmd.read) begin
			rd_cnt_q <= rd_cnt_q + 4'd1;
		end else begin
			rd_cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		ok_s1 <= ok_now;
		if (cmd.read && rd_cnt_q != '0) begin
			window_q[rd_cnt_q - 4'd1] <= ok_s1 ? rdata_s1 : '0;
		end
	end

	function automatic logic signed [11:0] tap(input logic [sem_pkg::PIX_BITS-1:0] px,
		input int ch);
		return signed'({4'b0000, px[8*ch +: 8]});
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.grad) begin
			for (int ch = 0; ch < 3; ch++) begin
				gx_s1[ch] <= (tap(window_q[2], ch) + (tap(window_q[5], ch) <<< 1)
					+ tap(window_q[8], ch)) - (tap(window_q[0], ch)
					+ (tap(window_q[3], ch) <<< 1) + tap(window_q[6], ch));
				gy_s1[ch] <= (tap(window_q[6], ch) + (tap(window_q[7], ch) <<< 1)
					+ tap(window_q[8], ch)) - (tap(window_q[0], ch)
					+ (tap(window_q[1], ch) <<< 1) + tap(window_q[2], ch));
			end
			alpha_q <= window_q[4][sem_pkg::PIX_BITS-1 -: 8];
		end
		if (cmd.square) begin
			for (int ch = 0; ch < 3; ch++) begin
				sq_q[ch]  <= 22'(24'(gx_s1[ch]) * 24'(gx_s1[ch])
					+ 24'(gy_s1[ch]) * 24'(gy_s1[ch]));
				res_q[ch] <= '0;
			end
		end
		// One result bit per cycle: keep a bit while (255*r)^2 <= 4096*S.
		if (cmd.root) begin
			for (int ch = 0; ch < 3; ch++) begin
				logic [7:0]  trial;
				logic [15:0] scaled;
				logic [31:0] sq_scaled;
				trial     = res_q[ch] | (8'd1 << bit_q);
				scaled    = {trial, 8'h00} - {8'h00, trial};
				sq_scaled = {16'h0000, scaled} * {16'h0000, scaled};
				if ({2'b00, sq_scaled} <= {sq_q[ch], sem_pkg::GAIN_SHIFT'(0)}) begin
					res_q[ch] <= trial;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= '0;
		end else if (cmd.square) begin
			bit_q <= 3'd7;
		end else if (cmd.root) begin
			bit_q <= bit_q - 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edges.valid <= 1'b0;
		end else if (cmd.load) begin
			edges.valid <= 1'b1;
		end else if (edges.ready) begin
			edges.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			edges.red_edge   <= res_q[0];
			edges.green_edge <= res_q[1];
			edges.blue_edge  <= res_q[2];
			edges.alpha_out  <= alpha_q;
			edges.frame_end  <= last_out;
		end
	end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       drain;
	} pixel_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       frame_end;
	} edge_t;

	localparam int RING = 2 * sem_pkg::MAX_WIDTH + 4;

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_we;
	logic                         cfg_index;
	logic [sem_pkg::CFG_BITS-1:0] cfg_data;

	sem_pixel_if pixels ();
	sem_edge_if  edges ();

	sobel_edge_magnitude_rgb dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pixels   (pixels),
		.edges    (edges)
	);

	// Shadow copy of the frame state.
	logic [31:0]                     line_ring [RING];
	logic [sem_pkg::WIDTH_BITS-1:0]  width_reg;
	logic [sem_pkg::HEIGHT_BITS-1:0] height_reg;
	int unsigned          in_col;
	int unsigned          in_row;
	int unsigned          out_pos;
	bit                   frame_in;
	edge_t                edge_queue [$];
	int                   errors;
	int                   sent;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic int unsigned eff_w();
		if (width_reg == 0) return 1;
		if (width_reg > sem_pkg::MAX_WIDTH) return sem_pkg::MAX_WIDTH;
		return width_reg;
	endfunction

	function automatic int unsigned eff_h();
		if (height_reg == 0) return 1;
		if (height_reg > sem_pkg::MAX_HEIGHT) return sem_pkg::MAX_HEIGHT;
		return height_reg;
	endfunction

	function automatic logic [7:0] edge_root(int gx, int gy);
		longint unsigned rhs;
		int unsigned     lo;
		int unsigned     hi;
		int unsigned     mid;
		rhs = 64'(4096) * longint'(gx * gx + gy * gy);
		lo = 0;
		hi = sem_pkg::FULL_SCALE;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (64'(65025) * mid * mid <= rhs) lo = mid;
			else hi = mid - 1;
		end
		return lo[7:0];
	endfunction

	function automatic void restart_shadow();
		in_col = 0;
		in_row = 0;
		out_pos = 0;
		frame_in = 0;
	endfunction

	function automatic void sobel_predict(pixel_t px);
		int unsigned w;
		int unsigned h;
		int unsigned total;
		int unsigned q;
		int unsigned r;
		int unsigned c;
		bit          emit;
		logic [31:0] win [9];
		int          v [9];
		int          gx;
		int          gy;
		edge_t       e;
		w = eff_w();
		h = eff_h();
		total = w * h;
		if (!px.drain && !frame_in) begin
			q = in_row * w + in_col;
			line_ring[q % RING] = {px.alpha, px.blue, px.green, px.red};
			in_col++;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
			end
			if (q + 1 >= total) frame_in = 1;
			emit = (q + 1) >= out_pos + w + 2;
		end else begin
			emit = frame_in;
		end
		if (!emit || out_pos >= total) return;
		r = out_pos / w;
		c = out_pos % w;
		for (int k = 0; k < 9; k++) begin
			int rr;
			int cc;
			rr = int'(r) + k / 3 - 1;
			cc = int'(c) + k % 3 - 1;
			win[k] = 0;
			if (rr >= 0 && rr < int'(h) && cc >= 0 && cc < int'(w))
				win[k] = line_ring[(rr * w + cc) % RING];
		end
		for (int ch = 0; ch < 3; ch++) begin
			for (int k = 0; k < 9; k++) v[k] = (win[k] >> (8 * ch)) & 8'hFF;
			gx = (v[2] + 2 * v[5] + v[8]) - (v[0] + 2 * v[3] + v[6]);
			gy = (v[6] + 2 * v[7] + v[8]) - (v[0] + 2 * v[1] + v[2]);
			case (ch)
				0: e.red = edge_root(gx, gy);
				1: e.green = edge_root(gx, gy);
				default: e.blue = edge_root(gx, gy);
			endcase
		end
		e.alpha = win[4][31:24];
		e.frame_end = (out_pos + 1 == total);
		edge_queue.push_back(e);
		if (e.frame_end) restart_shadow();
		else out_pos++;
	endfunction

	// The valid line stays high across back-to-back transfers unless a random gap drops it.
	task automatic send_pixel(pixel_t px);
		int gap;
		gap = $urandom_range(0, 6);
		if (gap > 0) begin
			pixels.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixels.valid <= 1'b1;
		pixels.red_in <= px.red;
		pixels.green_in <= px.green;
		pixels.blue_in <= px.blue;
		pixels.alpha_in <= px.alpha;
		pixels.drain <= px.drain;
		do @(posedge clk); while (!pixels.ready);
		sobel_predict(px);
		sent++;
	endtask

	task automatic send_random(bit drain, bit extreme);
		pixel_t px;
		px = {$urandom, 1'b0};
		if (extreme) begin
			px.red = {8{px.red[0]}};
			px.green = {8{px.green[0]}};
			px.blue = {8{px.blue[0]}};
		end
		px.drain = drain;
		send_pixel(px);
	endtask

	task automatic wait_drained();
		pixels.valid <= 1'b0;
		@(posedge clk);
		while (edge_queue.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic index, int unsigned value);
		wait_drained();
		repeat (30) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value[sem_pkg::CFG_BITS-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (index == sem_pkg::REG_IMAGE_WIDTH) width_reg = value[sem_pkg::WIDTH_BITS-1:0];
		else height_reg = value[sem_pkg::HEIGHT_BITS-1:0];
		restart_shadow();
	endtask

	// Sends a whole frame, then enough drain transfers to flush it.
	task automatic run_frame(bit extreme, bit noisy);
		int unsigned n;
		n = eff_w() * eff_h();
		for (int unsigned i = 0; i < n; i++) begin
			if (noisy && $urandom_range(0, 9) == 0) send_random(1'b1, 1'b0);
			send_random(1'b0, extreme);
		end
		for (int unsigned i = 0; i < eff_w() + 1; i++)
			send_random(noisy && $urandom_range(0, 3) == 0 ? 1'b0 : 1'b1, 1'b0);
	endtask

	task automatic test_reset_size();
		// Partial frame at the reset size: the first rows give a few results.
		for (int i = 0; i < 645; i++) send_random(1'b0, 1'b0);
		wait_drained();
	endtask

	task automatic test_small_frames();
		write_reg(sem_pkg::REG_IMAGE_WIDTH, 3);
		write_reg(sem_pkg::REG_IMAGE_HEIGHT, 3);
		run_frame(1'b1, 1'b0);
		// A drain before the frame is complete gives nothing.
		send_random(1'b1, 1'b0);
		run_frame(1'b0, 1'b0);
		write_reg(sem_pkg::REG_IMAGE_WIDTH, 0);
		write_reg(sem_pkg::REG_IMAGE_HEIGHT, 0);
		run_frame(1'b0, 1'b1);
		write_reg(sem_pkg::REG_IMAGE_WIDTH, 1);
		write_reg(sem_pkg::REG_IMAGE_HEIGHT, 5);
		run_frame(1'b1, 1'b0);
	endtask

	// Oversized and limit register values, each size with a short partial frame cut off by the next write.
	task automatic test_extreme_sizes();
		write_reg(sem_pkg::REG_IMAGE_WIDTH, 4095);
		write_reg(sem_pkg::REG_IMAGE_HEIGHT, 1);
		for (int i = 0; i < 30; i++) send_random(1'b0, 1'b0);
		write_reg(sem_pkg::REG_IMAGE_WIDTH, sem_pkg::MAX_WIDTH);
		write_reg(sem_pkg::REG_IMAGE_HEIGHT, 2);
		for (int i = 0; i < 30; i++) send_random(1'b0, 1'b0);
		write_reg(sem_pkg::REG_IMAGE_WIDTH, 1);
		write_reg(sem_pkg::REG_IMAGE_HEIGHT, 8191);
		for (int i = 0; i < 40; i++) send_random(1'b0, i % 2 == 0);
	endtask

	task automatic test_random_frames();
		int target;
		target = sent + 520;
		while (sent < target) begin
			write_reg(sem_pkg::REG_IMAGE_WIDTH, $urandom_range(1, 12));
			write_reg(sem_pkg::REG_IMAGE_HEIGHT, $urandom_range(1, 8));
			if ($urandom_range(0, 3) == 0) begin
				// Broken frame: a short random run of pixels and drains, then a restart by a register write.
				for (int i = $urandom_range(1, 20); i > 0; i--)
					send_random($urandom_range(0, 1) == 1, 1'b0);
			end else begin
				run_frame($urandom_range(0, 3) == 0, $urandom_range(0, 1) == 1);
			end
		end
	endtask

	task automatic test_pause();
		write_reg(sem_pkg::REG_IMAGE_WIDTH, 6);
		write_reg(sem_pkg::REG_IMAGE_HEIGHT, 6);
		for (int i = 0; i < 20; i++) send_random(1'b0, 1'b0);
		wait_drained();
		for (int i = 0; i < 16; i++) send_random(1'b0, 1'b0);
		for (int i = 0; i < 7; i++) send_random(1'b1, 1'b0);
	endtask

	// Result side: random stalls on ready, compare every transfer.
	int stall;
	always @(posedge clk or negedge arst_n) begin
		edge_t got;
		edge_t want;
		logic  rdy;
		if (!arst_n) begin
			edges.ready <= 1'b0;
			stall = 0;
		end else begin
			rdy = edges.ready;
			if (edges.valid && edges.ready) begin
				got = {edges.red_edge, edges.green_edge, edges.blue_edge,
					edges.alpha_out, edges.frame_end};
				if (edge_queue.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got);
					errors++;
				end else begin
					want = edge_queue.pop_front();
					if (got.red !== want.red)
						$display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
					if (got.green !== want.green)
						$display("%0t: green expected %0d actual %0d", $time, want.green,
							got.green);
					if (got.blue !== want.blue)
						$display("%0t: blue expected %0d actual %0d", $time, want.blue,
							got.blue);
					if (got.alpha !== want.alpha)
						$display("%0t: alpha expected %0d actual %0d", $time, want.alpha,
							got.alpha);
					if (got.frame_end !== want.frame_end)
						$display("%0t: frame_end expected %0d actual %0d", $time,
							want.frame_end, got.frame_end);
					if (got !== want) errors++;
				end
				stall = $urandom_range(0, 6);
			end
			if (stall > 0) begin
				stall--;
				rdy = 1'b0;
			end else begin
				rdy = 1'b1;
			end
			edges.ready <= rdy;
		end
	end

	initial begin
		errors = 0;
		sent = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = sem_pkg::REG_IMAGE_WIDTH;
		cfg_data = '0;
		pixels.valid = 1'b0;
		pixels.red_in = '0;
		pixels.green_in = '0;
		pixels.blue_in = '0;
		pixels.alpha_in = '0;
		pixels.drain = 1'b0;
		width_reg = sem_pkg::WIDTH_BITS'(sem_pkg::RESET_WIDTH);
		height_reg = sem_pkg::HEIGHT_BITS'(sem_pkg::RESET_HEIGHT);
		restart_shadow();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_size();
		test_small_frames();
		test_pause();
		test_extreme_sizes();
		test_random_frames();
		wait_drained();
		repeat (50) @(posedge clk);
		if (errors == 0 && edge_queue.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#100ms;
		$display("status: fail");
		$finish;
	end

endmodule
